FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers used by the RTL
// Each macro expects clk and arst_n to exist in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define TFFE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check an implication at every rising clock edge outside reset.
`define TFFE_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

FILE: src/tffe_pkg.sv
// ----------------------------------------------------------------------------
// tffe_pkg: shared types and helpers of the trap family fitness evaluator
// Mode codes, configuration snapshot type, score tables, small remainders.
// ----------------------------------------------------------------------------
`default_nettype none

package tffe_pkg;

	localparam int MAX_BITS_DEF = 4096;
	localparam int LEN_W        = 13;
	localparam int IDX_W        = 2;
	localparam int MODE_W       = 3;
	localparam int BO_W         = 3;
	localparam int SCORE_W      = 16;
	localparam int ADD_W        = 6;
	localparam logic [LEN_W-1:0] LEN_RST = 13'd4096;

	typedef enum logic [MODE_W-1:0] {
		MODE_ONEMAX = 3'd0,
		MODE_TRAP5  = 3'd1,
		MODE_CYCLIC = 3'd2,
		MODE_FOLD6  = 3'd3,
		MODE_LOFT   = 3'd4
	} tffe_mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_EVAL_MODE = 2'd0,
		REG_BIT_COUNT = 2'd1
	} tffe_reg_t;

	// Configuration as the core sees it, with length-derived terms precomputed.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [LEN_W-1:0]  len;
		logic              mis4;
		logic              mis5;
		logic              mis6;
		logic [LEN_W-2:0]  fold_len;
	} tffe_cfg_t;

	// x mod 5 through a reciprocal multiply, exact for 13-bit x
	function automatic logic [2:0] mod5(input logic [LEN_W-1:0] x);
		logic [25:0]      prod;
		logic [LEN_W-1:0] q;
		logic [LEN_W-1:0] r;
		prod = 26'(x) * 26'd6554;
		q    = LEN_W'(prod >> 15);
		r    = x - LEN_W'(q * 13'd5);
		return r[2:0];
	endfunction

	// x mod 6 through a reciprocal multiply, exact for 13-bit x
	function automatic logic [2:0] mod6(input logic [LEN_W-1:0] x);
		logic [27:0]      prod;
		logic [LEN_W-1:0] q;
		logic [LEN_W-1:0] r;
		prod = 28'(x) * 28'd10923;
		q    = LEN_W'(prod >> 16);
		r    = x - LEN_W'(q * 13'd6);
		return r[2:0];
	endfunction

	function automatic logic [BO_W-1:0] ones_add(input logic [BO_W-1:0] a,
		input logic b);
		logic [BO_W:0] s;
		s = {1'b0, a} + {{BO_W{1'b0}}, b};
		return s[BO_W] ? {BO_W{1'b1}} : s[BO_W-1:0];
	endfunction

	function automatic logic [ADD_W-1:0] trap5_score(input logic [BO_W-1:0] u);
		logic [ADD_W-1:0] v;
		case (u)
			3'd0: v = 6'd8;
			3'd1: v = 6'd6;
			3'd2: v = 6'd4;
			3'd3: v = 6'd2;
			3'd5: v = 6'd10;
			default: v = 6'd0;
		endcase
		return v;
	endfunction

	function automatic logic [ADD_W-1:0] fold6_score(input logic [BO_W-1:0] u);
		logic [ADD_W-1:0] v;
		case (u)
			3'd0, 3'd6: v = 6'd10;
			3'd2, 3'd4: v = 6'd4;
			3'd3:       v = 6'd8;
			default:    v = 6'd0;
		endcase
		return v;
	endfunction

	function automatic logic [ADD_W-1:0] loft_score(input logic [BO_W-1:0] u);
		logic [ADD_W-1:0] v;
		case (u)
			3'd0, 3'd6: v = 6'd60;
			3'd2, 3'd4: v = 6'd24;
			3'd3:       v = 6'd48;
			default:    v = 6'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: src/tffe_cfg.sv
// ----------------------------------------------------------------------------
// tffe_cfg: configuration registers
// Holds mode and length; clamps the length and precomputes its remainders.
// ----------------------------------------------------------------------------
`default_nettype none

module tffe_cfg #(
	parameter int MAX_BITS = tffe_pkg::MAX_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [tffe_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [tffe_pkg::LEN_W-1:0] cfg_data,
	output tffe_pkg::tffe_cfg_t             cfg
);
	import tffe_pkg::*;

	tffe_cfg_t cfg_q;

	function automatic tffe_cfg_t set_len(input tffe_cfg_t c, input logic [LEN_W-1:0] raw);
		tffe_cfg_t        r;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] half;
		r = c;
		if (raw == '0)
			len = LEN_W'(1);
		else if (int'(raw) > MAX_BITS)
			len = LEN_W'(MAX_BITS);
		else
			len = raw;
		half       = len >> 1;
		r.len      = len;
		r.mis4     = (len[1:0] != 2'd0);
		r.mis5     = (mod5(len) != 3'd0);
		r.mis6     = (mod6(len) != 3'd0);
		r.fold_len = (LEN_W-1)'(half - LEN_W'(mod6(half)));
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= set_len('{mode: MODE_TRAP5, default: '0}, LEN_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EVAL_MODE: cfg_q.mode <= cfg_data[MODE_W-1:0];
				REG_BIT_COUNT: cfg_q      <= set_len(cfg_q, cfg_data);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/tffe_core.sv
// ----------------------------------------------------------------------------
// tffe_core: per-bit scoring datapath
// Input register, running block state update and a result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tffe_core #(
	parameter int MAX_BITS = tffe_pkg::MAX_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tffe_pkg::tffe_cfg_t          cfg,
	input  wire logic                         gene_valid,
	output logic                              gene_stall,
	input  wire logic                         gene_bit,
	output logic                              fit_valid,
	input  wire logic                         fit_stall,
	output logic [tffe_pkg::SCORE_W-1:0]      fitness_tenths,
	output logic                              length_mismatch
);
	import tffe_pkg::*;

	localparam int POS_W = $clog2(MAX_BITS);
	localparam int CMP_W = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;

	// input stage
	logic               valid_s1;
	logic               bit_s1;

	// running chromosome state
	logic [POS_W-1:0]   pos_q;
	logic [2:0]         ph5_q;
	logic [2:0]         ph6_q;
	logic [BO_W-1:0]    bo_q;
	logic [SCORE_W-1:0] score_q;
	logic               first_q;
	logic               alive_q;

	// result register
	logic               res_valid_q;
	logic [SCORE_W-1:0] res_score_q;
	logic               res_mis_q;

	logic               last_c;
	logic               adv_s1;
	logic               fb_c;
	logic [BO_W-1:0]    bo_inc_c;
	logic [BO_W-1:0]    bo_mid_c;
	logic [BO_W-1:0]    bo_wrap_c;
	logic [BO_W-1:0]    bo_next_c;
	logic [ADD_W-1:0]   add_a_c;
	logic [ADD_W-1:0]   add_b_c;
	logic               alive_next_c;
	logic               mis_c;
	logic [SCORE_W+1:0] sum_c;
	logic [SCORE_W-1:0] score_next_c;

	assign last_c   = (CMP_W'(pos_q) + CMP_W'(1)) >= CMP_W'(cfg.len);
	assign fb_c     = (pos_q == '0) ? bit_s1 : first_q;
	assign bo_inc_c = ones_add(bo_q, bit_s1);

	always_comb begin
		add_a_c      = '0;
		add_b_c      = '0;
		bo_mid_c     = bo_inc_c;
		bo_wrap_c    = bo_inc_c;
		bo_next_c    = bo_q;
		alive_next_c = alive_q;
		mis_c        = 1'b0;
		case (cfg.mode)
			MODE_ONEMAX: begin
				add_a_c = bit_s1 ? ADD_W'(10) : '0;
			end
			MODE_CYCLIC: begin
				// a block boundary bit closes the previous block and opens the next
				if (pos_q != '0 && pos_q[1:0] == 2'd0) begin
					add_a_c  = trap5_score(bo_inc_c);
					bo_mid_c = {{(BO_W-1){1'b0}}, bit_s1};
				end
				bo_wrap_c = ones_add(bo_mid_c, fb_c);
				// last block wraps around to bit 0
				if (last_c && !cfg.mis4) begin
					add_b_c   = trap5_score(bo_wrap_c);
					bo_next_c = bo_wrap_c;
				end else begin
					bo_next_c = bo_mid_c;
				end
				mis_c = cfg.mis4;
			end
			MODE_FOLD6: begin
				bo_next_c = bo_inc_c;
				if (ph6_q == 3'd5) begin
					add_a_c   = fold6_score(bo_inc_c);
					bo_next_c = '0;
				end
				mis_c = cfg.mis6;
			end
			MODE_LOFT: begin
				if (CMP_W'(pos_q) < CMP_W'(cfg.fold_len)) begin
					bo_next_c = bo_inc_c;
					if (ph6_q == 3'd5) begin
						add_a_c   = loft_score(bo_inc_c);
						bo_next_c = '0;
					end
				end else if (alive_q && bit_s1) begin
					add_a_c = ADD_W'(10);
				end else begin
					alive_next_c = 1'b0;
				end
			end
			default: begin
				// trap5, also taken by the unused codes
				bo_next_c = bo_inc_c;
				if (ph5_q == 3'd4) begin
					add_a_c   = trap5_score(bo_inc_c);
					bo_next_c = '0;
				end
				mis_c = cfg.mis5;
			end
		endcase
		sum_c        = (SCORE_W+2)'(score_q) + (SCORE_W+2)'(add_a_c) + (SCORE_W+2)'(add_b_c);
		score_next_c = (sum_c > (SCORE_W+2)'({SCORE_W{1'b1}})) ? {SCORE_W{1'b1}}
			: sum_c[SCORE_W-1:0];
	end

	// an item that ends a chromosome waits only while the result slot is full and stalled
	assign adv_s1     = valid_s1 && (!last_c || !res_valid_q || !fit_stall);
	assign gene_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!gene_stall) begin
			valid_s1 <= gene_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (gene_valid && !gene_stall)
			bit_s1 <= gene_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ph5_q   <= '0;
			ph6_q   <= '0;
			bo_q    <= '0;
			score_q <= '0;
			first_q <= 1'b0;
			alive_q <= 1'b1;
		end else if (adv_s1) begin
			if (last_c) begin
				pos_q   <= '0;
				ph5_q   <= '0;
				ph6_q   <= '0;
				bo_q    <= '0;
				score_q <= '0;
				first_q <= 1'b0;
				alive_q <= 1'b1;
			end else begin
				pos_q   <= pos_q + POS_W'(1);
				ph5_q   <= (ph5_q == 3'd4) ? 3'd0 : ph5_q + 3'd1;
				ph6_q   <= (ph6_q == 3'd5) ? 3'd0 : ph6_q + 3'd1;
				bo_q    <= bo_next_c;
				score_q <= score_next_c;
				first_q <= fb_c;
				alive_q <= alive_next_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && last_c) begin
			res_valid_q <= 1'b1;
		end else if (!fit_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_c) begin
			res_score_q <= score_next_c;
			res_mis_q   <= mis_c;
		end
	end

	assign fit_valid       = res_valid_q;
	assign fitness_tenths  = res_score_q;
	assign length_mismatch = res_mis_q;

	`include "assert_macros.svh"

	`TFFE_ASSERT(a_phase_range, ph5_q <= 3'd4 && ph6_q <= 3'd5, "phase counter out of range")
	`TFFE_ASSERT_IMP(a_phase_start, pos_q == '0, ph5_q == 3'd0 && ph6_q == 3'd0, "phase not aligned to bit 0")
	`TFFE_ASSERT_IMP(a_clear_after_last, adv_s1 && last_c, ##1 (pos_q == '0 && score_q == '0 && alive_q), "state not cleared after last beat")
	`TFFE_ASSERT_IMP(a_score_monotone, adv_s1 && !last_c, ##1 (score_q >= $past(score_q)), "score decreased within a chromosome")

endmodule

`default_nettype wire

FILE: src/trap_family_fitness_evaluator.sv
// ----------------------------------------------------------------------------
// trap_family_fitness_evaluator: one chromosome bit per beat, fitness per chromosome
// Result path: the last bit is held in the input register, and its fitness is registered in the output register.
// Throughput: one bit per cycle, set by the block state update; a last bit
// waits only while the previous result is still held stalled in the output register.
// Reset: clears run state and the result valid flag; mode trap5, length 4096 (clamped to MAX_BITS).
// ----------------------------------------------------------------------------
`default_nettype none

module trap_family_fitness_evaluator #(
	parameter int MAX_BITS = tffe_pkg::MAX_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [tffe_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [tffe_pkg::LEN_W-1:0]   cfg_data,
	input  wire logic                         gene_valid,
	output logic                              gene_stall,
	input  wire logic                         gene_bit,
	output logic                              fit_valid,
	input  wire logic                         fit_stall,
	output logic [tffe_pkg::SCORE_W-1:0]      fitness_tenths,
	output logic                              length_mismatch
);
	import tffe_pkg::*;

	tffe_cfg_t cfg;

	tffe_cfg #(
		.MAX_BITS (MAX_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tffe_core #(
		.MAX_BITS (MAX_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.gene_valid      (gene_valid),
		.gene_stall      (gene_stall),
		.gene_bit        (gene_bit),
		.fit_valid       (fit_valid),
		.fit_stall       (fit_stall),
		.fitness_tenths  (fitness_tenths),
		.length_mismatch (length_mismatch)
	);

endmodule

`default_nettype wire
